@@ hw/rtl/acf_pkg.sv @@
// Shared types and codes for the association control state machine.
// No dependencies; imported by acf_decide and association_control_fsm_unit.
package acf_pkg;

  localparam int unsigned StateW = 4;
  localparam int unsigned TimerW = 16;

  localparam logic [StateW-1:0] ST1  = 4'd0;
  localparam logic [StateW-1:0] ST2  = 4'd1;
  localparam logic [StateW-1:0] ST4  = 4'd3;
  localparam logic [StateW-1:0] ST5  = 4'd4;
  localparam logic [StateW-1:0] ST6  = 4'd5;
  localparam logic [StateW-1:0] ST7  = 4'd6;
  localparam logic [StateW-1:0] ST13 = 4'd12;

  localparam logic [2:0] ACT_CONNECT  = 3'd0;
  localparam logic [2:0] ACT_TCONN    = 3'd1;
  localparam logic [2:0] ACT_INCOMING = 3'd2;
  localparam logic [2:0] ACT_PDU      = 3'd3;
  localparam logic [2:0] ACT_INVALID  = 3'd4;
  localparam logic [2:0] ACT_TERR     = 3'd5;
  localparam logic [2:0] ACT_SEND     = 3'd6;
  localparam logic [2:0] ACT_TICK     = 3'd7;

  localparam logic [2:0] PDU_RQ    = 3'd0;
  localparam logic [2:0] PDU_AC    = 3'd1;
  localparam logic [2:0] PDU_RJ    = 3'd2;
  localparam logic [2:0] PDU_DATA  = 3'd3;
  localparam logic [2:0] PDU_ABORT = 3'd4;

  localparam logic [2:0] SEND_NONE  = 3'd0;
  localparam logic [2:0] SEND_RQ    = 3'd1;
  localparam logic [2:0] SEND_AC    = 3'd2;
  localparam logic [2:0] SEND_RJ    = 3'd3;
  localparam logic [2:0] SEND_DATA  = 3'd4;
  localparam logic [2:0] SEND_ABORT = 3'd5;

  localparam logic SRC_USER     = 1'b0;
  localparam logic SRC_PROVIDER = 1'b1;

  localparam logic [1:0] RSN_UNRECOGNIZED = 2'd1;
  localparam logic [1:0] RSN_UNEXPECTED   = 2'd2;

  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  localparam logic [2:0] IND_NONE       = 3'd0;
  localparam logic [2:0] IND_ACCEPT     = 3'd1;
  localparam logic [2:0] IND_REJECT     = 3'd2;
  localparam logic [2:0] IND_DATA       = 3'd3;
  localparam logic [2:0] IND_ABORT      = 3'd4;
  localparam logic [2:0] IND_PROV_ABORT = 3'd5;

  localparam logic [TimerW-1:0] ARTIM_RESET = 16'd30;

  localparam logic CFG_ARTIM = 1'b0;
  localparam logic CFG_ROLE  = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] pdu_kind;
    logic       assoc_acceptable;
  } event_t;

  typedef struct packed {
    logic [StateW-1:0] next_state;
    logic [2:0]        send_pdu;
    logic              abort_source;
    logic [1:0]        abort_reason;
    logic [1:0]        timer_command;
    logic              close_link;
    logic              open_link;
    logic [2:0]        indication;
    logic              indication_source;
    logic              illegal_event;
  } result_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic dec;
  } tmr_upd_t;

endpackage

@@ hw/rtl/acf_decide.sv @@
// Event decode for the association control state machine: one event against
// the current state and timer gives the result and the timer update.
// Depends on acf_pkg.
module acf_decide (
  input  acf_pkg::event_t                 evt_i,
  input  logic [acf_pkg::StateW-1:0]      state_i,
  input  logic [acf_pkg::TimerW-1:0]      timer_count_i,
  input  logic                            timer_running_i,
  input  logic                            role_is_user_i,
  output acf_pkg::result_t                res_o,
  output acf_pkg::tmr_upd_t               tmr_o
);
  import acf_pkg::*;

  result_t r;
  logic    legal;
  logic    is_invalid;
  logic    kill;
  logic    dec;

  always_comb begin
    r            = '0;
    r.next_state = state_i;
    legal        = 1'b1;
    kill         = 1'b0;
    dec          = 1'b0;
    is_invalid   = (evt_i.action == ACT_INVALID) ||
                   ((evt_i.action == ACT_PDU) && (evt_i.pdu_kind > PDU_ABORT));

    if (state_i > ST13) begin
      legal = 1'b0;
    end else if (is_invalid) begin
      if (state_i == ST1 || state_i == ST4) begin
        legal = 1'b0;
      end else begin
        r.send_pdu     = SEND_ABORT;
        r.abort_reason = RSN_UNRECOGNIZED;
        r.next_state   = ST13;
        if (state_i == ST2) begin
          r.abort_source  = SRC_USER;
          r.timer_command = TMR_START;
        end else if (state_i != ST13) begin
          r.abort_source      = SRC_PROVIDER;
          r.indication        = IND_PROV_ABORT;
          r.indication_source = role_is_user_i;
          r.timer_command     = TMR_START;
        end
      end
    end else begin
      unique case (evt_i.action)
        ACT_CONNECT: begin
          if (state_i == ST1) begin
            r.open_link  = 1'b1;
            r.next_state = ST4;
          end else legal = 1'b0;
        end
        ACT_TCONN: begin
          if (state_i == ST4) begin
            r.send_pdu   = SEND_RQ;
            r.next_state = ST5;
          end else legal = 1'b0;
        end
        ACT_INCOMING: begin
          if (state_i == ST1) begin
            r.timer_command = TMR_START;
            r.next_state    = ST2;
          end else legal = 1'b0;
        end
        ACT_PDU: begin
          if (state_i == ST1 || state_i == ST4) begin
            legal = 1'b0;
          end else if (evt_i.pdu_kind == PDU_ABORT) begin
            r.close_link = 1'b1;
            r.next_state = ST1;
            if (state_i == ST2 || state_i == ST13) r.timer_command = TMR_STOP;
            else r.indication = IND_ABORT;
          end else if (evt_i.pdu_kind == PDU_RQ && state_i == ST2) begin
            if (evt_i.assoc_acceptable) begin
              r.send_pdu      = SEND_AC;
              r.timer_command = TMR_STOP;
              r.next_state    = ST6;
            end else begin
              r.send_pdu      = SEND_RJ;
              r.timer_command = TMR_START;
              r.next_state    = ST13;
            end
          end else if (evt_i.pdu_kind == PDU_RQ && state_i == ST13) begin
            r.send_pdu     = SEND_ABORT;
            r.abort_reason = RSN_UNEXPECTED;
          end else if (state_i == ST2) begin
            r.send_pdu      = SEND_ABORT;
            r.abort_reason  = RSN_UNEXPECTED;
            r.timer_command = TMR_START;
            r.next_state    = ST13;
          end else if (state_i == ST13) begin
            r.next_state = ST13;
          end else if (evt_i.pdu_kind == PDU_AC && state_i == ST5) begin
            r.indication = IND_ACCEPT;
            r.next_state = ST6;
          end else if (evt_i.pdu_kind == PDU_RJ && state_i == ST5) begin
            r.indication = IND_REJECT;
            r.close_link = 1'b1;
            r.next_state = ST1;
          end else if (evt_i.pdu_kind == PDU_DATA && state_i == ST6) begin
            r.indication = IND_DATA;
          end else if (evt_i.pdu_kind == PDU_DATA && state_i == ST7) begin
            r.next_state = ST7;
          end else begin
            r.send_pdu          = SEND_ABORT;
            r.abort_source      = SRC_PROVIDER;
            r.abort_reason      = RSN_UNEXPECTED;
            r.indication        = IND_PROV_ABORT;
            r.indication_source = role_is_user_i;
            r.timer_command     = TMR_START;
            r.next_state        = ST13;
          end
        end
        ACT_INVALID: begin
          legal = 1'b0;  // handled above
        end
        ACT_TERR: begin
          if (state_i == ST1) begin
            legal = 1'b0;
          end else if (state_i == ST2) begin
            r.timer_command = TMR_STOP;
            r.next_state    = ST1;
          end else if (state_i != ST13) begin
            r.indication        = IND_PROV_ABORT;
            r.indication_source = role_is_user_i;
            r.next_state        = ST1;
          end
        end
        ACT_SEND: begin
          if (state_i == ST6) r.send_pdu = SEND_DATA;
          else legal = 1'b0;
        end
        ACT_TICK: begin
          if (timer_running_i) begin
            if (timer_count_i > TimerW'(1)) begin
              dec = 1'b1;
            end else if (state_i == ST2 || state_i == ST13) begin
              r.timer_command = TMR_STOP;
              r.close_link    = 1'b1;
              r.next_state    = ST1;
            end else begin
              kill  = 1'b1;
              legal = 1'b0;
            end
          end
        end
        default: legal = 1'b0;
      endcase
    end

    if (!legal) begin
      r               = '0;
      r.next_state    = state_i;
      r.illegal_event = 1'b1;
    end

    res_o       = r;
    tmr_o.load  = legal && (r.timer_command == TMR_START);
    tmr_o.clear = (legal && (r.timer_command == TMR_STOP)) || kill;
    tmr_o.dec   = legal && dec;
  end

endmodule

@@ hw/rtl/association_control_fsm_unit.sv @@
// Top level of the association control state machine with ARTIM timer.
// Depends on acf_pkg and acf_decide.
//
// Usage:
//   Events enter on the input channel (action_i, pdu_kind_i,
//   assoc_acceptable_i), one transfer per cycle at most. Each event gives
//   exactly one result on the output channel: next state, PDU to send,
//   abort source and reason, timer command, link close/open, indication
//   and the illegal-event flag.
//   The event is captured in an input register, decoded combinationally
//   against the machine state and ARTIM counter, and the result register
//   loads together with the state and timer update.
//   Throughput is one event per cycle while the receiver does not stall,
//   set by the state and timer update loop.
//   When the receiver stalls, the result register holds; the input register
//   keeps taking one more event, then in_stall_o rises until it drains.
//   Configuration (index 0 ARTIM length, index 1 role) is written through
//   cfg_we_i while no events are in flight.
//   Reset puts the machine in Sta1 with the timer stopped, ARTIM length 30
//   and role provider; both channels come up empty.
module association_control_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [2:0]  pdu_kind_i,
  input  logic        assoc_acceptable_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  next_state_o,
  output logic [2:0]  send_pdu_o,
  output logic        abort_source_o,
  output logic [1:0]  abort_reason_o,
  output logic [1:0]  timer_command_o,
  output logic        close_link_o,
  output logic        open_link_o,
  output logic [2:0]  indication_o,
  output logic        indication_source_o,
  output logic        illegal_event_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import acf_pkg::*;

  logic              in_v_q;
  event_t            evt_q;
  logic              out_v_q;
  result_t           res_q;
  result_t           res_d;
  tmr_upd_t          tmr_upd;
  logic [StateW-1:0] state_q;
  logic [TimerW-1:0] count_q;
  logic [TimerW-1:0] count_d;
  logic              running_q;
  logic              running_d;
  logic [TimerW-1:0] artim_q;
  logic              role_q;
  logic              advance;
  logic              in_take;

  assign advance    = in_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && out_v_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  acf_decide u_decide (
    .evt_i           (evt_q),
    .state_i         (state_q),
    .timer_count_i   (count_q),
    .timer_running_i (running_q),
    .role_is_user_i  (role_q),
    .res_o           (res_d),
    .tmr_o           (tmr_upd)
  );

  always_comb begin
    count_d   = count_q;
    running_d = running_q;
    if (tmr_upd.load) begin
      count_d   = artim_q;
      running_d = 1'b1;
    end else if (tmr_upd.clear) begin
      count_d   = '0;
      running_d = 1'b0;
    end else if (tmr_upd.dec) begin
      count_d = count_q - TimerW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      state_q   <= ST1;
      count_q   <= '0;
      running_q <= 1'b0;
      artim_q   <= ARTIM_RESET;
      role_q    <= 1'b0;
    end else begin
      if (in_take) in_v_q <= 1'b1;
      else if (advance) in_v_q <= 1'b0;
      if (advance) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
      if (advance) begin
        state_q   <= res_d.next_state;
        count_q   <= count_d;
        running_q <= running_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ARTIM: artim_q <= cfg_wdata_i;
          CFG_ROLE:  role_q  <= cfg_wdata_i[0];
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) evt_q <= '{action: action_i, pdu_kind: pdu_kind_i,
                            assoc_acceptable: assoc_acceptable_i};
    if (advance) res_q <= res_d;
  end

  assign out_valid_o         = out_v_q;
  assign next_state_o        = res_q.next_state;
  assign send_pdu_o          = res_q.send_pdu;
  assign abort_source_o      = res_q.abort_source;
  assign abort_reason_o      = res_q.abort_reason;
  assign timer_command_o     = res_q.timer_command;
  assign close_link_o        = res_q.close_link;
  assign open_link_o         = res_q.open_link;
  assign indication_o        = res_q.indication;
  assign indication_source_o = res_q.indication_source;
  assign illegal_event_o     = res_q.illegal_event;

endmodule

@@ bench/tb_top.sv @@
// Testbench for association_control_fsm_unit: directed and random event streams with a
// behavioral predictor of the state table and ARTIM timer, checked per result field.
// Depends on acf_pkg and the RTL of association_control_fsm_unit.
`timescale 1ns / 1ps

module tb_top;
  import acf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_d = '0;
  logic [2:0]  pdu_kind_d = '0;
  logic        acceptable_d = 1'b0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [3:0]  next_state_o;
  logic [2:0]  send_pdu_o;
  logic        abort_source_o;
  logic [1:0]  abort_reason_o;
  logic [1:0]  timer_command_o;
  logic        close_link_o;
  logic        open_link_o;
  logic [2:0]  indication_o;
  logic        indication_source_o;
  logic        illegal_event_o;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  association_control_fsm_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .action_i           (action_d),
    .pdu_kind_i         (pdu_kind_d),
    .assoc_acceptable_i (acceptable_d),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .next_state_o       (next_state_o),
    .send_pdu_o         (send_pdu_o),
    .abort_source_o     (abort_source_o),
    .abort_reason_o     (abort_reason_o),
    .timer_command_o    (timer_command_o),
    .close_link_o       (close_link_o),
    .open_link_o        (open_link_o),
    .indication_o       (indication_o),
    .indication_source_o(indication_source_o),
    .illegal_event_o    (illegal_event_o),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  // predictor state and register copies
  logic [StateW-1:0] fsm_st = ST1;
  logic [TimerW-1:0] artim_cnt = '0;
  logic              artim_on = 1'b0;
  logic [TimerW-1:0] artim_len = ARTIM_RESET;
  logic              role_user = 1'b0;

  event_t  event_queue[$];
  result_t pending_results[$];
  event_t  cur_ev;
  int      n_queued = 0;
  int      n_events = 0;
  int      n_results = 0;
  int      n_settings = 1;
  int      errors = 0;
  int      tx_burst = 0;
  int      rx_burst = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  bit      quiet = 1'b0;
  int      idle_cycles = 0;

  function automatic result_t provider_abort(result_t r_in, logic [1:0] rsn);
    result_t r;
    r = r_in;
    r.send_pdu = SEND_ABORT;
    r.abort_source = SRC_PROVIDER;
    r.abort_reason = rsn;
    r.indication = IND_PROV_ABORT;
    r.indication_source = role_user;
    r.timer_command = TMR_START;
    r.next_state = ST13;
    return r;
  endfunction

  function automatic result_t next_association(event_t ev);
    result_t           r;
    logic [StateW-1:0] s;
    logic              legal;
    logic              bad_pdu;
    r = '0;
    s = fsm_st;
    r.next_state = s;
    legal = 1'b1;
    bad_pdu = (ev.action == ACT_INVALID) || (ev.action == ACT_PDU && ev.pdu_kind > PDU_ABORT);
    if (s > ST13) begin
      legal = 1'b0;
    end else if (bad_pdu) begin
      if (s == ST1 || s == ST4) begin
        legal = 1'b0;
      end else if (s == ST2) begin
        r.send_pdu = SEND_ABORT;
        r.abort_source = SRC_USER;
        r.abort_reason = RSN_UNRECOGNIZED;
        r.timer_command = TMR_START;
        r.next_state = ST13;
      end else if (s == ST13) begin
        r.send_pdu = SEND_ABORT;
        r.abort_source = SRC_USER;
        r.abort_reason = RSN_UNRECOGNIZED;
      end else begin
        r = provider_abort(r, RSN_UNRECOGNIZED);
      end
    end else begin
      case (ev.action)
        ACT_CONNECT: begin
          if (s == ST1) begin
            r.open_link = 1'b1;
            r.next_state = ST4;
          end else legal = 1'b0;
        end
        ACT_TCONN: begin
          if (s == ST4) begin
            r.send_pdu = SEND_RQ;
            r.next_state = ST5;
          end else legal = 1'b0;
        end
        ACT_INCOMING: begin
          if (s == ST1) begin
            r.timer_command = TMR_START;
            r.next_state = ST2;
          end else legal = 1'b0;
        end
        ACT_PDU: begin
          if (s == ST1 || s == ST4) begin
            legal = 1'b0;
          end else if (ev.pdu_kind == PDU_ABORT) begin
            if (s == ST2 || s == ST13) r.timer_command = TMR_STOP;
            else r.indication = IND_ABORT;
            r.close_link = 1'b1;
            r.next_state = ST1;
          end else if (ev.pdu_kind == PDU_RQ) begin
            if (s == ST2) begin
              if (ev.assoc_acceptable) begin
                r.send_pdu = SEND_AC;
                r.timer_command = TMR_STOP;
                r.next_state = ST6;
              end else begin
                r.send_pdu = SEND_RJ;
                r.timer_command = TMR_START;
                r.next_state = ST13;
              end
            end else if (s == ST13) begin
              r.send_pdu = SEND_ABORT;
              r.abort_source = SRC_USER;
              r.abort_reason = RSN_UNEXPECTED;
            end else begin
              r = provider_abort(r, RSN_UNEXPECTED);
            end
          end else if (s == ST2) begin
            r.send_pdu = SEND_ABORT;
            r.abort_source = SRC_USER;
            r.abort_reason = RSN_UNEXPECTED;
            r.timer_command = TMR_START;
            r.next_state = ST13;
          end else if (s == ST13) begin
            r.next_state = ST13;
          end else if (ev.pdu_kind == PDU_AC && s == ST5) begin
            r.indication = IND_ACCEPT;
            r.next_state = ST6;
          end else if (ev.pdu_kind == PDU_RJ && s == ST5) begin
            r.indication = IND_REJECT;
            r.close_link = 1'b1;
            r.next_state = ST1;
          end else if (ev.pdu_kind == PDU_DATA && s == ST6) begin
            r.indication = IND_DATA;
          end else if (ev.pdu_kind == PDU_DATA && s == ST7) begin
            r.next_state = ST7;
          end else begin
            r = provider_abort(r, RSN_UNEXPECTED);
          end
        end
        ACT_TERR: begin
          if (s == ST1) begin
            legal = 1'b0;
          end else if (s == ST2) begin
            r.timer_command = TMR_STOP;
            r.next_state = ST1;
          end else if (s != ST13) begin
            r.indication = IND_PROV_ABORT;
            r.indication_source = role_user;
            r.next_state = ST1;
          end
        end
        ACT_SEND: begin
          if (s == ST6) r.send_pdu = SEND_DATA;
          else legal = 1'b0;
        end
        ACT_TICK: begin
          if (artim_on) begin
            if (artim_cnt > 1) begin
              artim_cnt = artim_cnt - 1'b1;
            end else if (s == ST2 || s == ST13) begin
              r.timer_command = TMR_STOP;
              r.close_link = 1'b1;
              r.next_state = ST1;
            end else begin
              artim_on = 1'b0;
              artim_cnt = '0;
              legal = 1'b0;
            end
          end
        end
        default: legal = 1'b0;
      endcase
    end
    if (!legal) begin
      r = '0;
      r.next_state = s;
      r.illegal_event = 1'b1;
    end else begin
      fsm_st = r.next_state;
      if (r.timer_command == TMR_START) begin
        artim_cnt = artim_len;
        artim_on = 1'b1;
      end else if (r.timer_command == TMR_STOP) begin
        artim_cnt = '0;
        artim_on = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // driver: predicts each accepted transfer, then presents the next queued event
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        pending_results.push_back(next_association(cur_ev));
        n_events++;
      end
      if (!in_valid || !in_stall_o) begin
        if (tx_burst > 0) begin
          tx_burst--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
          tx_burst = $urandom_range(1, 9) - 1;
          in_valid <= 1'b0;
        end else if (event_queue.size() > 0) begin
          cur_ev = event_queue.pop_front();
          action_d <= cur_ev.action;
          pdu_kind_d <= cur_ev.pdu_kind;
          acceptable_d <= cur_ev.assoc_acceptable;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no expected result (next_state %0d)", next_state_o);
          errors++;
        end else begin
          result_t want;
          want = pending_results.pop_front();
          check_field("next_state", want.next_state, next_state_o);
          check_field("send_pdu", want.send_pdu, send_pdu_o);
          check_field("abort_source", want.abort_source, abort_source_o);
          check_field("abort_reason", want.abort_reason, abort_reason_o);
          check_field("timer_command", want.timer_command, timer_command_o);
          check_field("close_link", want.close_link, close_link_o);
          check_field("open_link", want.open_link, open_link_o);
          check_field("indication", want.indication, indication_o);
          check_field("indication_source", want.indication_source, indication_source_o);
          check_field("illegal_event", want.illegal_event, illegal_event_o);
        end
        n_results++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (n_results >= 150 && !hold_done) begin
        // long back-pressure so the input side fills and stalls
        hold_done = 1'b1;
        hold_left = 60;
        out_stall <= 1'b1;
      end else if (rx_burst > 0) begin
        rx_burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_burst = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 3000) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic add_ev(logic [2:0] act, logic [2:0] kind, logic ok);
    event_t ev;
    ev.action = act;
    ev.pdu_kind = kind;
    ev.assoc_acceptable = ok;
    event_queue.push_back(ev);
    n_queued++;
  endtask

  task automatic add_any(logic [2:0] act);
    add_ev(act, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_pdu(logic [2:0] kind);
    add_ev(ACT_PDU, kind, 1'($urandom_range(0, 1)));
  endtask

  task automatic add_ticks(int n);
    for (int i = 0; i < n; i++) add_any(ACT_TICK);
  endtask

  task automatic wait_drained();
    while (n_events != n_queued || pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_ARTIM) artim_len = val;
    else role_user = val[0];
  endtask

  // mostly well-formed associations with random content, plus some noise
  task automatic gen_random(int count);
    int start;
    int pick;
    int n;
    start = n_queued;
    while (n_queued - start < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        add_any(ACT_CONNECT);
        add_any(ACT_TCONN);
        if ($urandom_range(0, 3) == 0) add_pdu(3'($urandom_range(0, 7)));
        else if ($urandom_range(0, 2) == 0) add_pdu(PDU_RJ);
        else add_pdu(PDU_AC);
      end else if (pick < 8) begin
        add_any(ACT_INCOMING);
        add_ticks($urandom_range(0, 2));
        add_ev(ACT_PDU, PDU_RQ, 1'($urandom_range(0, 3) != 0));
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_any(3'($urandom_range(0, 7)));
      end
      if (pick < 8) begin
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: add_any(ACT_SEND);
            1: add_pdu(PDU_DATA);
            2: add_any(ACT_TICK);
            default: add_pdu(3'($urandom_range(0, 7)));
          endcase
        end
        case ($urandom_range(0, 4))
          0: add_pdu(PDU_ABORT);
          1: add_any(ACT_TERR);
          2: add_any(ACT_INVALID);
          3: add_pdu(3'($urandom_range(0, 7)));
          default: add_pdu(PDU_RQ);
        endcase
        add_ticks($urandom_range(0, 4));
      end
    end
  endtask

  initial begin
    logic [15:0] artim_set[6];
    logic        role_set[6];
    artim_set = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd2, 16'd0};
    role_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    artim_set[5] = 16'($urandom_range(1, 6));
    role_set[5] = 1'($urandom_range(0, 1));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed walk through both association paths at reset settings
    add_any(ACT_CONNECT);
    add_any(ACT_TCONN);
    add_ev(ACT_PDU, PDU_AC, 1'b0);
    add_ev(ACT_SEND, 3'd7, 1'b1);
    add_ev(ACT_PDU, PDU_DATA, 1'b1);
    add_ev(ACT_CONNECT, 3'd0, 1'b0);
    add_ev(ACT_PDU, PDU_ABORT, 1'b0);
    add_ev(ACT_TICK, 3'd7, 1'b1);
    add_ev(ACT_PDU, 3'd7, 1'b1);
    add_ev(ACT_INCOMING, 3'd0, 1'b0);
    add_ev(ACT_PDU, PDU_RQ, 1'b1);
    add_ev(ACT_INVALID, 3'd0, 1'b0);
    add_ev(ACT_PDU, PDU_RQ, 1'b0);
    add_ev(ACT_TERR, 3'd0, 1'b0);
    add_ev(ACT_PDU, PDU_DATA, 1'b0);
    add_ev(ACT_INVALID, 3'd5, 1'b1);
    add_ev(ACT_PDU, PDU_ABORT, 1'b1);
    add_ev(ACT_INCOMING, 3'd7, 1'b1);
    add_ev(ACT_PDU, PDU_RQ, 1'b0);
    add_ev(ACT_PDU, 3'd5, 1'b0);
    add_ev(ACT_PDU, PDU_ABORT, 1'b0);
    add_ev(ACT_CONNECT, 3'd0, 1'b0);
    add_ev(ACT_TCONN, 3'd0, 1'b0);
    add_ev(ACT_PDU, PDU_RJ, 1'b1);
    add_ev(ACT_TERR, 3'd7, 1'b1);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_reg(CFG_ARTIM, artim_set[p]);
      write_reg(CFG_ROLE, {15'd0, role_set[p]});
      n_settings++;
      if (p == 5) quiet = 1'b1;
      gen_random(88);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d events, checked %0d results over %0d register settings,",
             n_events, n_results, n_settings);
    $display("including ARTIM lengths 0, 1 and 65535 and both roles.");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
